### src/tsm_pkg.sv
// package for the tensor similarity metrics block
// holds sizes, constants, the sequencer state type and the multiplier select type; no dependencies
`timescale 1ns / 1ps
package tsm_pkg;
  localparam int ElemWidth = 16;
  localparam logic [16:0] MaxLen = 17'd65536;
  localparam logic [15:0] ThreshReset = 16'd41;
  localparam int FracCos = 14;
  localparam int DivSteps = 64;
  localparam int SqrtSteps = 47;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RT,
    ST_MUL_RR,
    ST_MUL_TT,
    ST_ADD_TT,
    ST_NORM_MUL,
    ST_SQRT,
    ST_DIV_MEAN,
    ST_DIV_COS,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MS_RT,
    MS_RR,
    MS_TT,
    MS_A0B0,
    MS_A0B1,
    MS_A1B0,
    MS_A1B1
  } mul_sel_t;
endpackage

### src/tensor_similarity_metrics_top.sv
// Tensor similarity metrics: pairs of 16-bit elements in, one metrics result per vector out.
// A pair is accepted in the idle state and then takes three products through the single
// shared 25x25 multiplier and the last norm add before the next pair can be accepted; a pair
// beyond the length limit is dropped in its accept cycle. A pair marked tlast then goes on to
// the 94-bit norm product (four partial products), the square root, the mean division, the
// cosine division and the cosine sign and clamp (both skipped when a norm is zero), and the
// load of the output register. Input stays not ready until the result is loaded, which waits
// while a previous result is still held in the output register.
// Input tdata: ref_value [15:0], test_value [31:16]; tlast marks the last pair.
// Depends on tsm_pkg.
`timescale 1ns / 1ps
module tensor_similarity_metrics_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ref_value [15:0], test_value [31:16]
  input  logic [31:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // max_abs_diff [15:0], mean_abs_diff [31:16], cosine [47:32], ref_argmax [63:48],
  // test_argmax [79:64], index_match [80], pass_flag [81], element_count [98:82],
  // length_overflow [99], zero fill [103:100]
  output logic [103:0] m_axis_tdata
);

  tsm_pkg::state_t   state, state_next;
  tsm_pkg::mul_sel_t mul_sel;

  logic [15:0] threshold;
  logic signed [15:0] ref_in, test_in;
  logic        last_in;

  logic [15:0] running_max_diff;
  logic [31:0] running_sum_diff;
  logic [47:0] running_dot;
  logic [46:0] ref_norm_sq, test_norm_sq;
  logic signed [15:0] ref_best_value, test_best_value;
  logic [15:0] ref_best_index, test_best_index;
  logic [16:0] pair_counter;
  logic        overflow_seen;

  logic [6:0]  step;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;

  logic [93:0] norm_prod;
  logic [49:0] sq_rem;
  logic [46:0] sq_root;
  logic [63:0] div_num;
  logic [48:0] div_rem;
  logic [47:0] div_den;
  logic [15:0] mean_r, cos_r;

  logic [16:0] abs_diff;
  logic        accept;
  logic [49:0] sq_shift, sq_trial;
  logic [48:0] div_shift;
  logic        div_ge;
  logic        dot_neg;
  logic [47:0] dot_mag;
  logic [14:0] q_clamp;
  logic [93:0] prod_shifted;
  logic        cos_pending;
  logic        out_load;

  assign cfg_ready = 1'b1;
  assign accept = s_axis_tvalid && s_axis_tready;

  // cosine sign and clamp still to do, then output register load
  assign cos_pending = (step == '0) && (pair_counter != '0) && (sq_root != '0);
  assign out_load = (state == tsm_pkg::ST_EMIT) && !cos_pending &&
                    (!m_axis_tvalid || m_axis_tready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tsm_pkg::ThreshReset;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tsm_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (pair_counter < tsm_pkg::MaxLen) state_next = tsm_pkg::ST_MUL_RT;
          else if (s_axis_tlast) state_next = tsm_pkg::ST_NORM_MUL;
        end
      end
      tsm_pkg::ST_MUL_RT: state_next = tsm_pkg::ST_MUL_RR;
      tsm_pkg::ST_MUL_RR: state_next = tsm_pkg::ST_MUL_TT;
      tsm_pkg::ST_MUL_TT: state_next = tsm_pkg::ST_ADD_TT;
      tsm_pkg::ST_ADD_TT: state_next = last_in ? tsm_pkg::ST_NORM_MUL : tsm_pkg::ST_IDLE;
      tsm_pkg::ST_NORM_MUL: if (step == 7'd4) state_next = tsm_pkg::ST_SQRT;
      tsm_pkg::ST_SQRT: if (step == 7'(tsm_pkg::SqrtSteps - 1)) state_next = tsm_pkg::ST_DIV_MEAN;
      tsm_pkg::ST_DIV_MEAN: begin
        if (step == 7'(tsm_pkg::DivSteps - 1)) begin
          state_next = (sq_root != '0) ? tsm_pkg::ST_DIV_COS : tsm_pkg::ST_EMIT;
        end
      end
      tsm_pkg::ST_DIV_COS: if (step == 7'(tsm_pkg::DivSteps - 1)) state_next = tsm_pkg::ST_EMIT;
      tsm_pkg::ST_EMIT: if (out_load) state_next = tsm_pkg::ST_IDLE;
      default: state_next = tsm_pkg::ST_IDLE;
    endcase
  end

  // control outputs: handshake and multiplier operand select
  always_comb begin
    s_axis_tready = (state == tsm_pkg::ST_IDLE);
    mul_sel = tsm_pkg::MS_RT;
    case (state)
      tsm_pkg::ST_MUL_RR: mul_sel = tsm_pkg::MS_RR;
      tsm_pkg::ST_MUL_TT: mul_sel = tsm_pkg::MS_TT;
      tsm_pkg::ST_NORM_MUL: begin
        case (step)
          7'd0: mul_sel = tsm_pkg::MS_A0B0;
          7'd1: mul_sel = tsm_pkg::MS_A0B1;
          7'd2: mul_sel = tsm_pkg::MS_A1B0;
          default: mul_sel = tsm_pkg::MS_A1B1;
        endcase
      end
      default: mul_sel = tsm_pkg::MS_RT;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (mul_sel)
      tsm_pkg::MS_RT: begin mul_a = 25'(ref_in); mul_b = 25'(test_in); end
      tsm_pkg::MS_RR: begin mul_a = 25'(ref_in); mul_b = 25'(ref_in); end
      tsm_pkg::MS_TT: begin mul_a = 25'(test_in); mul_b = 25'(test_in); end
      tsm_pkg::MS_A0B0: begin
        mul_a = {1'b0, ref_norm_sq[23:0]}; mul_b = {1'b0, test_norm_sq[23:0]};
      end
      tsm_pkg::MS_A0B1: begin
        mul_a = {1'b0, ref_norm_sq[23:0]}; mul_b = {2'b0, test_norm_sq[46:24]};
      end
      tsm_pkg::MS_A1B0: begin
        mul_a = {2'b0, ref_norm_sq[46:24]}; mul_b = {1'b0, test_norm_sq[23:0]};
      end
      default: begin
        mul_a = {2'b0, ref_norm_sq[46:24]}; mul_b = {2'b0, test_norm_sq[46:24]};
      end
    endcase
  end

  // datapath helpers
  always_comb begin
    abs_diff = (ref_in >= test_in) ? 17'(32'(ref_in) - 32'(test_in))
                                   : 17'(32'(test_in) - 32'(ref_in));
    case (step)
      7'd1: prod_shifted = {46'b0, prod[47:0]};
      7'd4: prod_shifted = {prod[45:0], 48'b0};
      default: prod_shifted = {22'b0, prod[47:0], 24'b0};
    endcase
    sq_shift = {sq_rem[47:0], norm_prod[93:92]};
    sq_trial = {1'b0, sq_root, 2'b01};
    div_shift = {div_rem[47:0], div_num[63]};
    div_ge = div_shift >= {1'b0, div_den};
    dot_neg = running_dot[47];
    dot_mag = dot_neg ? (~running_dot + 48'd1) : running_dot;
    q_clamp = (div_num[63:15] != '0 || div_num[14:0] > 15'd16384) ? 15'd16384
                                                                     : div_num[14:0];
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // sequencer, accumulators and shared units
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsm_pkg::ST_IDLE;
      step <= '0;
      running_max_diff <= '0;
      running_sum_diff <= '0;
      running_dot <= '0;
      ref_norm_sq <= '0;
      test_norm_sq <= '0;
      ref_best_value <= '0;
      test_best_value <= '0;
      ref_best_index <= '0;
      test_best_index <= '0;
      pair_counter <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      prod <= mul_a * mul_b;
      case (state)
        tsm_pkg::ST_IDLE: begin
          step <= '0;
          norm_prod <= '0;
          if (accept) begin
            ref_in <= s_axis_tdata[15:0];
            test_in <= s_axis_tdata[31:16];
            last_in <= s_axis_tlast;
            if (pair_counter >= tsm_pkg::MaxLen) overflow_seen <= 1'b1;
          end
        end
        tsm_pkg::ST_MUL_RT: begin
          // compare and count updates for this pair
          if (abs_diff[15:0] > running_max_diff) running_max_diff <= abs_diff[15:0];
          running_sum_diff <= running_sum_diff + 32'(abs_diff);
          if (pair_counter == '0 || ref_in > ref_best_value) begin
            ref_best_value <= ref_in;
            ref_best_index <= pair_counter[15:0];
          end
          if (pair_counter == '0 || test_in > test_best_value) begin
            test_best_value <= test_in;
            test_best_index <= pair_counter[15:0];
          end
          pair_counter <= pair_counter + 17'd1;
        end
        tsm_pkg::ST_MUL_RR: running_dot <= running_dot + {{16{prod[31]}}, prod[31:0]};
        tsm_pkg::ST_MUL_TT: ref_norm_sq <= ref_norm_sq + prod[46:0];
        tsm_pkg::ST_ADD_TT: test_norm_sq <= test_norm_sq + prod[46:0];
        tsm_pkg::ST_NORM_MUL: begin
          // partial products of the norm product
          if (step != '0) norm_prod <= norm_prod + prod_shifted;
          if (step == 7'd4) begin
            step <= '0;
            sq_rem <= '0;
            sq_root <= '0;
          end else begin
            step <= step + 7'd1;
          end
        end
        tsm_pkg::ST_SQRT: begin
          // two bits of radicand per step
          norm_prod <= {norm_prod[91:0], 2'b00};
          if (sq_shift >= sq_trial) begin
            sq_rem <= sq_shift - sq_trial;
            sq_root <= {sq_root[45:0], 1'b1};
          end else begin
            sq_rem <= sq_shift;
            sq_root <= {sq_root[45:0], 1'b0};
          end
          if (step == 7'(tsm_pkg::SqrtSteps - 1)) begin
            step <= '0;
            div_num <= {32'b0, running_sum_diff};
            div_den <= {31'b0, pair_counter};
            div_rem <= '0;
          end else begin
            step <= step + 7'd1;
          end
        end
        tsm_pkg::ST_DIV_MEAN, tsm_pkg::ST_DIV_COS: begin
          // restoring division, one quotient bit per step
          if (step == 7'(tsm_pkg::DivSteps - 1) && state == tsm_pkg::ST_DIV_MEAN) begin
            step <= '0;
            mean_r <= (pair_counter == '0) ? 16'd0 : {div_num[14:0], div_ge};
            cos_r <= '0;
            // load the cosine division
            div_num <= {2'b0, dot_mag, {tsm_pkg::FracCos{1'b0}}};
            div_den <= {1'b0, sq_root};
            div_rem <= '0;
          end else begin
            div_rem <= div_ge ? (div_shift - {1'b0, div_den}) : div_shift;
            div_num <= {div_num[62:0], div_ge};
            if (step == 7'(tsm_pkg::DivSteps - 1)) begin
              step <= '0;
            end else begin
              step <= step + 7'd1;
            end
          end
        end
        tsm_pkg::ST_EMIT: begin
          if (cos_pending) begin
            cos_r <= dot_neg ? (16'd0 - {1'b0, q_clamp}) : {1'b0, q_clamp};
            step <= 7'd1;
          end else if (out_load) begin
            m_axis_tdata[15:0] <= running_max_diff;
            m_axis_tdata[31:16] <= mean_r;
            m_axis_tdata[47:32] <= cos_r;
            m_axis_tdata[63:48] <= ref_best_index;
            m_axis_tdata[79:64] <= test_best_index;
            m_axis_tdata[80] <= (ref_best_index == test_best_index);
            m_axis_tdata[81] <= (ref_best_index == test_best_index) &&
                                (running_max_diff <= threshold);
            m_axis_tdata[98:82] <= pair_counter;
            m_axis_tdata[99] <= overflow_seen;
            m_axis_tdata[103:100] <= '0;
            // clear for the next vector
            running_max_diff <= '0;
            running_sum_diff <= '0;
            running_dot <= '0;
            ref_norm_sq <= '0;
            test_norm_sq <= '0;
            ref_best_value <= '0;
            test_best_value <= '0;
            ref_best_index <= '0;
            test_best_index <= '0;
            pair_counter <= '0;
            overflow_seen <= 1'b0;
            step <= '0;
          end
        end
        default: step <= '0;
      endcase
    end
  end

endmodule

### tb/tensor_similarity_metrics_checker.sv
// checker for the tensor similarity metrics block: watches the config, input and
// result channels, predicts each result and compares it field by field
// depends on tsm_pkg
`timescale 1ns / 1ps
module tensor_similarity_metrics_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  output int           fail_count,
  output int           pending_count
);

  typedef struct packed {
    logic [15:0] max_abs_diff;
    logic [15:0] mean_abs_diff;
    logic [15:0] cosine;
    logic [15:0] ref_argmax;
    logic [15:0] test_argmax;
    logic        index_match;
    logic        pass_flag;
    logic [16:0] element_count;
    logic        length_overflow;
  } metrics_t;

  metrics_t    metrics_q[$];
  logic [15:0] threshold;
  logic [15:0] max_diff;
  logic [31:0] sum_diff;
  logic [47:0] dot_acc;
  logic [46:0] ref_norm;
  logic [46:0] test_norm;
  logic signed [15:0] ref_best;
  logic signed [15:0] test_best;
  logic [15:0] ref_best_idx;
  logic [15:0] test_best_idx;
  logic [16:0] pair_count;
  logic        dropped;

  // floor of the square root of the full norm product
  function automatic logic [63:0] root_of_product(logic [46:0] a, logic [46:0] b);
    logic [127:0] prod;
    logic [63:0]  root;
    logic [63:0]  cand;
    prod = 128'(a) * 128'(b);
    root = '0;
    for (int bit_pos = 47; bit_pos >= 0; bit_pos--) begin
      cand = root | (64'd1 << bit_pos);
      if (128'(cand) * 128'(cand) <= prod) root = cand;
    end
    return root;
  endfunction

  function automatic metrics_t finish_vector();
    metrics_t     m;
    logic [63:0]  den;
    logic [47:0]  mag;
    logic [127:0] quot;
    den = root_of_product(ref_norm, test_norm);
    m.max_abs_diff = max_diff;
    m.mean_abs_diff = 16'(sum_diff / 32'(pair_count));
    m.cosine = '0;
    if (den != 0) begin
      mag = dot_acc[47] ? -dot_acc : dot_acc;
      quot = (128'(mag) << tsm_pkg::FracCos) / 128'(den);
      if (quot > (128'd1 << tsm_pkg::FracCos)) quot = 128'd1 << tsm_pkg::FracCos;
      m.cosine = dot_acc[47] ? 16'(-quot[15:0]) : quot[15:0];
    end
    m.ref_argmax = ref_best_idx;
    m.test_argmax = test_best_idx;
    m.index_match = (ref_best_idx == test_best_idx);
    m.pass_flag = m.index_match && (max_diff <= threshold);
    m.element_count = pair_count;
    m.length_overflow = dropped;
    return m;
  endfunction

  task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // accumulate each pair transfer, compare each result transfer
  always @(posedge clk) begin
    logic signed [15:0] r;
    logic signed [15:0] t;
    logic [15:0]        ad;
    metrics_t           exp_m;
    metrics_t           act_m;
    if (rst) begin
      threshold = tsm_pkg::ThreshReset;
      max_diff = '0; sum_diff = '0; dot_acc = '0; ref_norm = '0; test_norm = '0;
      ref_best = '0; test_best = '0; ref_best_idx = '0; test_best_idx = '0;
      pair_count = '0; dropped = 1'b0;
      metrics_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        act_m.max_abs_diff = m_axis_tdata[15:0];
        act_m.mean_abs_diff = m_axis_tdata[31:16];
        act_m.cosine = m_axis_tdata[47:32];
        act_m.ref_argmax = m_axis_tdata[63:48];
        act_m.test_argmax = m_axis_tdata[79:64];
        act_m.index_match = m_axis_tdata[80];
        act_m.pass_flag = m_axis_tdata[81];
        act_m.element_count = m_axis_tdata[98:82];
        act_m.length_overflow = m_axis_tdata[99];
        if (metrics_q.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          exp_m = metrics_q.pop_front();
          check_field("max_abs_diff", 17'(exp_m.max_abs_diff), 17'(act_m.max_abs_diff));
          check_field("mean_abs_diff", 17'(exp_m.mean_abs_diff), 17'(act_m.mean_abs_diff));
          check_field("cosine", 17'(exp_m.cosine), 17'(act_m.cosine));
          check_field("ref_argmax", 17'(exp_m.ref_argmax), 17'(act_m.ref_argmax));
          check_field("test_argmax", 17'(exp_m.test_argmax), 17'(act_m.test_argmax));
          check_field("index_match", 17'(exp_m.index_match), 17'(act_m.index_match));
          check_field("pass_flag", 17'(exp_m.pass_flag), 17'(act_m.pass_flag));
          check_field("element_count", exp_m.element_count, act_m.element_count);
          check_field("length_overflow", 17'(exp_m.length_overflow),
                      17'(act_m.length_overflow));
          check_field("zero_fill", 17'd0, 17'(m_axis_tdata[103:100]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        r = s_axis_tdata[15:0];
        t = s_axis_tdata[31:16];
        if (pair_count < tsm_pkg::MaxLen) begin
          ad = 16'((32'(r) - 32'(t)) < 0 ? (32'(t) - 32'(r)) : (32'(r) - 32'(t)));
          if (ad > max_diff) max_diff = ad;
          sum_diff = sum_diff + 32'(ad);
          dot_acc = dot_acc + 48'(32'(r) * 32'(t));
          ref_norm = ref_norm + 47'(32'(r) * 32'(r));
          test_norm = test_norm + 47'(32'(t) * 32'(t));
          if (pair_count == 0 || r > ref_best) begin
            ref_best = r; ref_best_idx = pair_count[15:0];
          end
          if (pair_count == 0 || t > test_best) begin
            test_best = t; test_best_idx = pair_count[15:0];
          end
          pair_count = pair_count + 17'd1;
        end else begin
          dropped = 1'b1;
        end
        if (s_axis_tlast) begin
          metrics_q.push_back(finish_vector());
          max_diff = '0; sum_diff = '0; dot_acc = '0; ref_norm = '0; test_norm = '0;
          ref_best = '0; test_best = '0; ref_best_idx = '0; test_best_idx = '0;
          pair_count = '0; dropped = 1'b0;
        end
      end
    end
    pending_count = metrics_q.size();
  end

  // leftover expectations are reported by the top through pending_count
endmodule

### tb/tensor_similarity_metrics_top_test.sv
// testbench top for the tensor similarity metrics block: drives vectors with random
// gaps in most phases, and threshold writes; hands checking to the checker module
// depends on tsm_pkg, tensor_similarity_metrics_top and the checker
`timescale 1ns / 1ps
module tensor_similarity_metrics_top_test;
  localparam int DrainCycles = 250;
  localparam int WatchdogLimit = 5000;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // ref_value [15:0], test_value [31:16]
  logic [31:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // max_abs_diff [15:0], mean_abs_diff [31:16], cosine [47:32], ref_argmax [63:48],
  // test_argmax [79:64], index_match [80], pass_flag [81], element_count [98:82],
  // length_overflow [99], zero fill [103:100]
  logic [103:0] m_axis_tdata;
  int           fail_count;
  int           pending_count;
  int           quiet_cycles;
  bit           send_gaps;
  bit           recv_gaps;

  tensor_similarity_metrics_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  tensor_similarity_metrics_checker metrics_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pair(logic [15:0] r, logic [15:0] t, logic last);
    int gap;
    gap = send_gaps ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {t, r};
    s_axis_tlast = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // write the threshold once every result is out and the block has gone quiet
  task automatic write_threshold(logic [15:0] value);
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random vectors, some with close test values so the pass check goes both ways
  task automatic random_vectors(int pair_budget);
    int          sent;
    int          len;
    int          style;
    logic [15:0] r;
    logic [15:0] t;
    sent = 0;
    while (sent < pair_budget) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
      style = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        r = 16'($urandom());
        case (style)
          0: t = 16'($urandom());
          1: t = r + 16'($urandom_range(0, 80)) - 16'd40;
          2: t = r;
          default: begin
            r = 16'($urandom_range(0, 7)) - 16'd4;
            t = 16'($urandom_range(0, 7)) - 16'd4;
          end
        endcase
        send_pair(r, t, i == len - 1);
      end
      sent += len;
    end
  endtask

  // ready side: runs of ready broken by random stalls
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (recv_gaps) begin
        m_axis_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  // watchdog over cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, zero norm, ties, identical and opposite vectors
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h1234, 1'b1);
    send_pair(16'h0100, 16'h0100, 1'b0);
    send_pair(16'h0100, 16'h0100, 1'b0);
    send_pair(16'h0100, 16'h0029, 1'b1);
    send_pair(16'h1000, 16'hf000, 1'b0);
    send_pair(16'h7fff, 16'h8001, 1'b1);
    send_pair(16'h0fff, 16'h0fff, 1'b0);
    send_pair(16'h8000, 16'h7fff, 1'b0);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'hffff, 16'h0001, 1'b0);
    send_pair(16'h0001, 16'hffff, 1'b1);
    send_pair(16'h0000, 16'h002a, 1'b1);
    write_threshold(16'd0);
    send_pair(16'h0010, 16'h0010, 1'b1);
    send_pair(16'h0010, 16'h0011, 1'b1);
    write_threshold(16'hffff);
    send_pair(16'h7fff, 16'h8000, 1'b1);

    random_vectors(350);
    write_threshold(16'($urandom_range(1, 100)));
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    random_vectors(200);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    write_threshold(16'($urandom()));
    random_vectors(250);
    write_threshold(16'd41);
    random_vectors(250);

    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
